>>> rtl/core/msgs_pkg.sv
// ----------------------------------------------------------------------------
// msgs_pkg: shared types and constants of the medoid swap gain search
// Payload structs for the pair and result channels, widths of the fixed
// fields, and the sequencer state type.
// ----------------------------------------------------------------------------
package msgs_pkg;

  localparam int MAX_MEDOIDS      = 16;
  localparam int POINT_INDEX_BITS = 16;
  localparam int DIST_BITS        = 32;
  localparam int CHG_W            = 52;
  localparam int SLOT_FIELD_W     = 4;
  localparam int CFG_W            = 5;

  typedef struct packed {
    logic [POINT_INDEX_BITS-1:0] candidate_index;
    logic [DIST_BITS-1:0]        candidate_nearest;
    logic [DIST_BITS-1:0]        pair_distance;
    logic [DIST_BITS-1:0]        point_nearest;
    logic [DIST_BITS-1:0]        point_second;
    logic [SLOT_FIELD_W-1:0]     point_medoid;
    logic                        is_self;
    logic                        first_pair;
    logic                        last_pair;
    logic                        last_candidate;
  } msgs_in_t;

  typedef struct packed {
    logic signed [CHG_W-1:0]     candidate_min_change;
    logic [SLOT_FIELD_W-1:0]     candidate_min_slot;
    logic                        pass_done;
    logic                        swap_found;
    logic [SLOT_FIELD_W-1:0]     swap_slot;
    logic [POINT_INDEX_BITS-1:0] swap_point;
    logic signed [CHG_W-1:0]     swap_gain;
  } msgs_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } msgs_state_t;

endpackage

>>> rtl/core/medoid_swap_gain_search_top.sv
// ----------------------------------------------------------------------------
// medoid_swap_gain_search_top: swap step of a k-medoids search
// Accumulates per-slot loss changes over the pairs of each candidate, reports
// the best slot per candidate and the best negative swap at the end of a pass.
// ----------------------------------------------------------------------------
// Usage. Pairs arrive on the item channel (item_valid, item_stall, item); a
// transfer happens on a rising edge with item_valid high and item_stall low.
// Results leave on the result channel under the same rule, one result for
// each pair that has last_pair set and none otherwise. The number of slots in
// use is written through cfg_wr_en and cfg_wr_data; the user writes it only
// while the block is idle, and the block itself does not enforce this. A
// pair is taken only while idle; the block stays busy until its slot walk
// ends and any result is loaded. One saturating adder walks the slot memory
// one entry per cycle, read registered, add, write back, and the minimum
// over the slots is tracked on the same walk, so the slot walk sets the
// rate. A result waits in an output register, so a stalled receiver does
// not stop the next pair from being taken; only a second result then waits.
// Reset (synchronous, rst high) sets all slot changes and the best swap to
// zero and the slot count to one, and empties the output register.
// ----------------------------------------------------------------------------
module medoid_swap_gain_search_top #(
  parameter int MAX_MEDOIDS = msgs_pkg::MAX_MEDOIDS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  msgs_pkg::msgs_in_t            item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output msgs_pkg::msgs_out_t           result,
  input  logic                          cfg_wr_en,
  input  logic [msgs_pkg::CFG_W-1:0]    cfg_wr_data
);

  localparam int CHG_W  = msgs_pkg::CHG_W;
  localparam int SFW    = msgs_pkg::SLOT_FIELD_W;
  localparam int SLOT_W = (MAX_MEDOIDS > 1) ? $clog2(MAX_MEDOIDS) : 1;
  localparam int N_W    = $clog2(MAX_MEDOIDS + 1);
  localparam int CW     = (N_W > msgs_pkg::CFG_W) ? N_W : msgs_pkg::CFG_W;
  localparam int IW     = (SLOT_W > SFW) ? SLOT_W : SFW;

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_MEDOIDS);
  localparam logic signed [CHG_W-1:0] CHG_MAX = {1'b0, {(CHG_W-1){1'b1}}};
  localparam logic signed [CHG_W-1:0] CHG_MIN = {1'b1, {(CHG_W-1){1'b0}}};

  msgs_pkg::msgs_state_t state, state_next;

  logic item_accept;
  logic rd_issue;
  logic res_load;

  // Configuration and the slot count it implies.
  logic [msgs_pkg::CFG_W-1:0] num_medoids;
  logic [CW-1:0]              nm_ext;
  logic [N_W-1:0]             active_now;

  // Fields of the pair under work.
  logic [N_W-1:0]                         active;
  logic [msgs_pkg::POINT_INDEX_BITS-1:0]  cand;
  logic signed [CHG_W-1:0]                own_term;
  logic signed [CHG_W-1:0]                other_term;
  logic [SFW-1:0]                         pm;
  logic                                   self_pair;
  logic                                   d_below_b;
  logic                                   last_pair;
  logic                                   last_cand;

  // Slot store: entries not rewritten since the last first pair read as base.
  logic signed [CHG_W-1:0]  mem [MAX_MEDOIDS];
  logic [MAX_MEDOIDS-1:0]   slot_ok;
  logic signed [CHG_W-1:0]  base;

  logic [N_W-1:0]           issue_idx;
  logic                     rd_go;
  logic [SLOT_W-1:0]        rd_idx;
  logic                     rd_ok;
  logic signed [CHG_W-1:0]  rd_data;

  logic signed [CHG_W-1:0]  cur_val;
  logic signed [CHG_W-1:0]  term;
  logic signed [CHG_W:0]    sum;
  logic signed [CHG_W-1:0]  new_val;

  logic signed [CHG_W-1:0]  mn;
  logic [SLOT_W-1:0]        ms;

  logic signed [CHG_W-1:0]                best_change;
  logic [msgs_pkg::POINT_INDEX_BITS-1:0]  best_point;
  logic [SLOT_W-1:0]                      best_slot;

  logic                                   better;
  logic signed [CHG_W-1:0]                nb_change;
  logic [msgs_pkg::POINT_INDEX_BITS-1:0]  nb_point;
  logic [SLOT_W-1:0]                      nb_slot;

  logic signed [CHG_W-1:0] d_ext;
  logic signed [CHG_W-1:0] b_ext;
  logic signed [CHG_W-1:0] s_ext;
  logic signed [CHG_W-1:0] c_ext;

  assign item_accept = item_valid && !item_stall;

  // Slot count in use: zero acts as one, anything above the store depth
  // acts as the depth.
  assign nm_ext = CW'(num_medoids);
  always_comb begin
    if (nm_ext == '0) begin
      active_now = N_W'(1);
    end else if (nm_ext > MAX_CNT) begin
      active_now = N_W'(MAX_MEDOIDS);
    end else begin
      active_now = N_W'(nm_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_medoids <= msgs_pkg::CFG_W'(1);
    end else if (cfg_wr_en) begin
      num_medoids <= cfg_wr_data;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msgs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      msgs_pkg::ST_IDLE: begin
        if (item_accept) state_next = msgs_pkg::ST_SCAN;
      end
      msgs_pkg::ST_SCAN: begin
        if (issue_idx == active - N_W'(1)) state_next = msgs_pkg::ST_DRAIN;
      end
      msgs_pkg::ST_DRAIN: begin
        state_next = last_pair ? msgs_pkg::ST_RESULT : msgs_pkg::ST_IDLE;
      end
      msgs_pkg::ST_RESULT: begin
        if (!result_valid || !result_stall) state_next = msgs_pkg::ST_IDLE;
      end
      default: state_next = msgs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall = 1'b1;
    rd_issue   = 1'b0;
    res_load   = 1'b0;
    unique case (state)
      msgs_pkg::ST_IDLE:   item_stall = 1'b0;
      msgs_pkg::ST_SCAN:   rd_issue = 1'b1;
      msgs_pkg::ST_DRAIN:  rd_issue = 1'b0;
      msgs_pkg::ST_RESULT: res_load = !result_valid || !result_stall;
      default:             item_stall = 1'b1;
    endcase
  end

  // Pair capture. Both contributions are formed once here, at full change
  // width, so the walk only selects between them.
  assign d_ext = CHG_W'(item.pair_distance);
  assign b_ext = CHG_W'(item.point_nearest);
  assign s_ext = CHG_W'(item.point_second);
  assign c_ext = CHG_W'(item.candidate_nearest);

  always_ff @(posedge clk) begin
    if (item_accept) begin
      active     <= active_now;
      cand       <= item.candidate_index;
      own_term   <= ((item.pair_distance < item.point_second) ? d_ext : s_ext) - b_ext;
      other_term <= d_ext - b_ext;
      pm         <= item.point_medoid;
      self_pair  <= item.is_self;
      d_below_b  <= item.pair_distance < item.point_nearest;
      last_pair  <= item.last_pair;
      last_cand  <= item.last_candidate;
    end
  end

  // Walk counter and read stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_idx <= '0;
      rd_go     <= 1'b0;
    end else begin
      rd_go <= rd_issue;
      if (item_accept) begin
        issue_idx <= '0;
      end else if (rd_issue) begin
        issue_idx <= issue_idx + N_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[issue_idx[SLOT_W-1:0]];
    rd_idx  <= issue_idx[SLOT_W-1:0];
    rd_ok   <= slot_ok[issue_idx[SLOT_W-1:0]];
  end

  // Saturating update of one slot.
  assign cur_val = rd_ok ? rd_data : base;

  always_comb begin
    if (self_pair) begin
      term = '0;
    end else if (IW'(rd_idx) == IW'(pm)) begin
      term = own_term;
    end else if (d_below_b) begin
      term = other_term;
    end else begin
      term = '0;
    end
  end

  assign sum = {cur_val[CHG_W-1], cur_val} + {term[CHG_W-1], term};

  always_comb begin
    if (sum[CHG_W] != sum[CHG_W-1]) begin
      new_val = sum[CHG_W] ? CHG_MIN : CHG_MAX;
    end else begin
      new_val = sum[CHG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_go) begin
      mem[rd_idx] <= new_val;
    end
  end

  // A first pair resets every slot at once by moving the base and dropping
  // all entry flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_ok <= '0;
      base    <= '0;
    end else if (item_accept && item.first_pair) begin
      slot_ok <= '0;
      base    <= CHG_W'(0) - c_ext;
    end else if (rd_go) begin
      slot_ok[rd_idx] <= 1'b1;
    end
  end

  // Running minimum over the walk; strict compare keeps the lowest slot.
  always_ff @(posedge clk) begin
    if (rd_go && ((rd_idx == '0) || (new_val < mn))) begin
      mn <= new_val;
      ms <= rd_idx;
    end
  end

  // Best swap of the pass.
  assign better    = mn < best_change;
  assign nb_change = better ? mn : best_change;
  assign nb_point  = better ? cand : best_point;
  assign nb_slot   = better ? ms : best_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      best_change <= '0;
      best_point  <= '0;
      best_slot   <= '0;
    end else if (res_load) begin
      if (last_cand) begin
        best_change <= '0;
        best_point  <= '0;
        best_slot   <= '0;
      end else begin
        best_change <= nb_change;
        best_point  <= nb_point;
        best_slot   <= nb_slot;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.candidate_min_change <= mn;
      result.candidate_min_slot   <= SFW'(ms);
      result.pass_done            <= last_cand;
      result.swap_found           <= last_cand && nb_change[CHG_W-1];
      result.swap_slot            <= last_cand ? SFW'(nb_slot) : '0;
      result.swap_point           <= last_cand ? nb_point : '0;
      result.swap_gain            <= last_cand ? nb_change : '0;
    end
  end

endmodule
